// ===== design/msbbs_pkg.sv =====
// shared constants, codes and interface types of the msb-first bit stream reader/writer
`timescale 1ns / 1ps

package msbbs_pkg;

    // byte store size and derived widths
    localparam int BYTE_DEPTH = 4096;
    localparam int ADDR_W     = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
    localparam int BYTE_BITS  = 8;
    localparam int MAX_BITS   = 64;
    localparam int CAP_BITS   = BYTE_DEPTH * BYTE_BITS;
    localparam int CAP_W      = $clog2(CAP_BITS + 1) + 1;

    // field widths
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int VALUE_W  = 64;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = POS_W + 1;

    // access window: up to nine bytes around a 64-bit field
    localparam int MAX_BYTES = 9;
    localparam int WIN_W     = MAX_BYTES * BYTE_BITS;
    localparam int NB_W      = 4;
    localparam int OFF_W     = 3;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEEK  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_END       = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CAPACITY  = 2'd3;

    // request from the control fsm to the byte engine
    typedef struct packed {
        logic               start;
        logic               write;
        logic [ADDR_W-1:0]  addr_first;
        logic [ADDR_W-1:0]  addr_last;
        logic [NB_W-1:0]    nbytes;
        logic [OFF_W-1:0]   offset;
        logic [OFF_W-1:0]   pad;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
    } eng_req_t;

    // answer of the byte engine
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } eng_rsp_t;

endpackage

// ===== design/msbbs_engine.sv =====
// byte store with a byte-serial read and read-modify-write engine
`timescale 1ns / 1ps

module msbbs_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  msbbs_pkg::eng_req_t req,
    output msbbs_pkg::eng_rsp_t rsp
);
    import msbbs_pkg::*;

    logic [BYTE_BITS-1:0] mem [BYTE_DEPTH];

    logic                 busy_reg,     busy_next;
    logic                 pend_reg,     pend_next;
    logic [NB_W-1:0]      left_reg,     left_next;
    logic [ADDR_W-1:0]    addr_reg,     addr_next;
    logic [ADDR_W-1:0]    pend_addr_reg;
    logic                 write_reg,    write_next;
    logic [OFF_W-1:0]     pad_reg,      pad_next;
    logic [BYTE_BITS-1:0] first_mask_reg, first_mask_next;
    logic [WIN_W-1:0]     data_reg,     data_next;
    logic [WIN_W-1:0]     mask_reg,     mask_next;
    logic [WIN_W-1:0]     acc_reg,      acc_next;
    logic [BYTE_BITS-1:0] rdata_reg;

    logic                 issue;
    logic                 done;
    logic                 wr_en;
    logic [BYTE_BITS-1:0] wr_data;
    logic [VALUE_W-1:0]   count_mask;
    logic [WIN_W-1:0]     shifted_acc;

    // thermometer mask of the low count bits
    always_comb begin
        for (int i = 0; i < VALUE_W; i++) begin
            count_mask[i] = (COUNT_W'(i) < req.count);
        end
    end

    assign issue   = busy_reg && (left_reg != '0);
    assign done    = busy_reg && (left_reg == '0) && !pend_reg;
    assign wr_en   = pend_reg && write_reg;
    assign wr_data = (rdata_reg & ~mask_reg[BYTE_BITS-1:0])
                   | (data_reg[BYTE_BITS-1:0] & mask_reg[BYTE_BITS-1:0]);

    // drop the trailing bits of the last byte
    assign shifted_acc = acc_reg >> pad_reg;
    assign rsp.done    = done;
    assign rsp.value   = shifted_acc[VALUE_W-1:0];

    // sequencer: one byte address issued per cycle, its data returned in the next cycle
    always_comb begin
        busy_next       = busy_reg;
        pend_next       = issue;
        left_next       = left_reg;
        addr_next       = addr_reg;
        write_next      = write_reg;
        pad_next        = pad_reg;
        first_mask_next = first_mask_reg;
        data_next       = data_reg;
        mask_next       = mask_reg;
        acc_next        = acc_reg;

        if (req.start) begin
            busy_next       = 1'b1;
            write_next      = req.write;
            pad_next        = req.pad;
            left_next       = req.nbytes;
            addr_next       = req.write ? req.addr_last : req.addr_first;
            first_mask_next = 8'hFF >> req.offset;
            data_next       = {{(WIN_W-VALUE_W){1'b0}}, req.value & count_mask} << req.pad;
            mask_next       = {{(WIN_W-VALUE_W){1'b0}}, count_mask} << req.pad;
            acc_next        = '0;
        end else begin
            if (issue) begin
                left_next = left_reg - NB_W'(1);
                addr_next = write_reg ? addr_reg - ADDR_W'(1) : addr_reg + ADDR_W'(1);
            end
            // returned byte: merge for a write, collect for a read
            if (pend_reg) begin
                if (write_reg) begin
                    data_next = data_reg >> BYTE_BITS;
                    mask_next = mask_reg >> BYTE_BITS;
                end else begin
                    acc_next        = {acc_reg[WIN_W-BYTE_BITS-1:0],
                                       rdata_reg & first_mask_reg};
                    first_mask_next = 8'hFF;
                end
            end
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            left_reg <= left_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        pend_addr_reg  <= addr_reg;
        write_reg      <= write_next;
        pad_reg        <= pad_next;
        first_mask_reg <= first_mask_next;
        data_reg       <= data_next;
        mask_reg       <= mask_next;
        acc_reg        <= acc_next;
    end

    // byte store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pend_addr_reg] <= wr_data;
        end
        if (issue) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // checks
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (left_reg <= NB_W'(MAX_BYTES)))
        else $error("byte counter beyond window");

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> busy_reg)
        else $error("byte returned while engine idle");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("engine started while busy");

endmodule

// ===== design/msb_first_bit_stream_reader_writer.sv =====
// top level: msb-first bit stream reader/writer over a byte store
`timescale 1ns / 1ps

// Reads, writes and seeks a bit stream held in a 4096-byte store, bit 7 of
// byte k being stream bit 8k. One transfer is handled at a time. A read or
// write of n bits at cursor c touches nb = ((c+n-1)>>3) - (c>>3) + 1 bytes
// (1 to 9), moved one at a time by the byte engine; writes read-modify-write
// each byte, pipelined so that the read of one byte overlaps the write of the
// byte before. Seeks, the unused mode and rejected items skip the byte engine
// and go from the check state straight to the done state. A finished result
// waits in the output register while the next item is taken; a second result
// holds the block until that register is free. Store contents need no
// clearing after reset: a read only returns stream bits already written.

module msb_first_bit_stream_reader_writer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [msbbs_pkg::MODE_W-1:0]       s_mode,
    input  logic [msbbs_pkg::COUNT_W-1:0]      s_bit_count,
    input  logic [msbbs_pkg::VALUE_W-1:0]      s_write_value,
    input  logic [msbbs_pkg::POS_W-1:0]        s_seek_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [msbbs_pkg::VALUE_W-1:0]      m_read_value,
    output logic [msbbs_pkg::STATUS_W-1:0]     m_status,
    output logic [msbbs_pkg::POS_W-1:0]        m_cursor_after,
    output logic [msbbs_pkg::POS_W-1:0]        m_length_after,
    output logic                               m_at_end
);
    import msbbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_ACCESS = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     cursor_reg, cursor_next;
    logic [POS_W-1:0]     length_reg, length_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [POS_W-1:0]     seek_reg;
    logic [VALUE_W-1:0]   rv_reg, rv_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   m_read_value_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [POS_W-1:0]     m_cursor_reg;
    logic [POS_W-1:0]     m_length_reg;
    logic                 m_at_end_reg;

    logic                 s_xfer;
    logic                 out_load;
    logic                 bad_count;
    logic                 eng_start;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     last_bit;
    eng_req_t             req;
    eng_rsp_t             rsp;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // end of the field and the byte window it covers
    assign bad_count = (count_reg == '0) || (count_reg > COUNT_W'(MAX_BITS));
    assign sum       = {1'b0, cursor_reg} + SUM_W'(count_reg);
    assign last_bit  = sum - SUM_W'(1);

    always_comb begin
        req.start      = eng_start;
        req.write      = (mode_reg == MODE_WRITE);
        req.addr_first = ADDR_W'(cursor_reg >> 3);
        req.addr_last  = ADDR_W'(last_bit >> 3);
        req.nbytes     = NB_W'((last_bit >> 3) - SUM_W'(cursor_reg >> 3) + SUM_W'(1));
        req.offset     = cursor_reg[OFF_W-1:0];
        req.pad        = OFF_W'(4'd8 - {1'b0, sum[OFF_W-1:0]});
        req.count      = count_reg;
        req.value      = value_reg;
    end

    // control fsm
    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        length_next  = length_reg;
        rv_next      = rv_reg;
        status_next  = status_reg;
        eng_start    = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                rv_next     = '0;
                status_next = STAT_OK;
                state_next  = S_DONE;
                case (mode_reg)
                    MODE_READ: begin
                        if (bad_count) begin
                            status_next = STAT_BAD_COUNT;
                        end else if (sum > {1'b0, length_reg}) begin
                            status_next = STAT_END;
                        end else begin
                            eng_start  = 1'b1;
                            state_next = S_ACCESS;
                        end
                    end
                    MODE_WRITE: begin
                        if (bad_count) begin
                            status_next = STAT_BAD_COUNT;
                        end else if (CAP_W'(sum) > CAP_W'(CAP_BITS)) begin
                            status_next = STAT_CAPACITY;
                        end else begin
                            eng_start  = 1'b1;
                            state_next = S_ACCESS;
                        end
                    end
                    MODE_SEEK: begin
                        if (seek_reg > length_reg) begin
                            status_next = STAT_END;
                        end else begin
                            cursor_next = seek_reg;
                        end
                    end
                    default: begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            S_ACCESS: begin
                if (rsp.done) begin
                    rv_next     = (mode_reg == MODE_READ) ? rsp.value : '0;
                    cursor_next = sum[POS_W-1:0];
                    if ((mode_reg == MODE_WRITE) && (sum > {1'b0, length_reg})) begin
                        length_next = sum[POS_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cursor_reg  <= '0;
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // input capture and result registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mode_reg  <= s_mode;
            count_reg <= s_bit_count;
            value_reg <= s_write_value;
            seek_reg  <= s_seek_position;
        end
        rv_reg     <= rv_next;
        status_reg <= status_next;
        if (out_load) begin
            m_read_value_reg <= rv_reg;
            m_status_reg     <= status_reg;
            m_cursor_reg     <= cursor_reg;
            m_length_reg     <= length_reg;
            m_at_end_reg     <= (cursor_reg >= length_reg);
        end
    end

    msbbs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_read_value_reg;
    assign m_status       = m_status_reg;
    assign m_cursor_after = m_cursor_reg;
    assign m_length_after = m_length_reg;
    assign m_at_end       = m_at_end_reg;

    // checks
    a_cursor_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= length_reg)
        else $error("cursor beyond stream length");

    a_length_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (length_reg >= $past(length_reg)))
        else $error("stream length shrank");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STAT_OK)) |-> (m_read_value_reg == '0))
        else $error("nonzero read value on error");

    a_engine_only_access: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == S_ACCESS))
        else $error("engine finished outside access");

endmodule
